// ----- sv/pos_list_pkg.sv -----
`default_nettype none

package pos_list_pkg;

  // Field widths of the item and result ports.
  localparam int KIND_W  = 3;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int STATUS_W = 2;

  localparam int CAPACITY_DEF = 16;

  typedef logic [VALUE_W-1:0] value_t;

  // Operation codes.
  localparam logic [KIND_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [KIND_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [KIND_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [KIND_W-1:0] OP_REPLACE = 3'd3;
  localparam logic [KIND_W-1:0] OP_READ    = 3'd4;
  localparam logic [KIND_W-1:0] OP_CLEAR   = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ----- sv/positional_list_engine_top.sv -----
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values, addressed by 1-based
// position. An item carries an operation (append, insert, delete, replace,
// read or clear), a position and a value, and is taken at a rising edge where
// start is high and busy is low. Every item gives exactly one result on the
// out_ ports: the value read (zero unless a read succeeded), the element
// count after the operation and a status (ok, position out of range, full).
// The item is captured in an input register; in the following cycle the
// whole list is updated in one pass, with every slot shifting in parallel
// for insert and delete, and the result is captured in the result register.
// out_valid, registered from in_valid_r, is high for exactly one cycle per
// result. The receiver cannot hold results off, and none is needed: busy is
// always low, so one item is taken and one result is given every cycle.
// Back-to-back items see each other's updates because the list update and
// the next item's input register land on the same edge.
// Reset empties the list (count zero) and drops any item in flight; the
// slot contents are not reset and are never read before written.
module positional_list_engine_top #(
  parameter int CAPACITY = pos_list_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [pos_list_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [pos_list_pkg::POS_W-1:0]     in_position,
  input  wire logic [pos_list_pkg::VALUE_W-1:0]   in_value,
  output logic                                    out_valid,
  output logic [pos_list_pkg::VALUE_W-1:0]        out_read_value,
  output logic [pos_list_pkg::COUNT_W-1:0]        out_element_count,
  output logic [pos_list_pkg::STATUS_W-1:0]       out_status
);
  import pos_list_pkg::*;

  // Count must hold CAPACITY itself; slot index covers 0..CAPACITY-1.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  // Comparison width wide enough for both the position and count+1.
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Input register.
  logic                in_valid_r;
  logic [KIND_W-1:0]   kind_r;
  logic [POS_W-1:0]    position_r;
  value_t              value_r;

  // List state.
  value_t              store_r [CAPACITY];
  value_t              store_nxt [CAPACITY];
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;

  // Result register.
  logic                out_valid_r;
  value_t              read_value_r;
  value_t              read_value_nxt;
  logic [CW-1:0]       count_out_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;

  // Position decode.
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       cnt_ext;
  logic [PW-1:0]       p0;
  logic                pos_ok;
  logic                ins_ok;
  logic                full;

  assign busy = 1'b0;

  assign pos_ext = PW'(position_r);
  assign cnt_ext = PW'(count_r);
  assign p0      = pos_ext - PW'(1);
  // Delete, replace and read take positions 1..count; insert takes 1..count+1.
  assign pos_ok  = (position_r != '0) && (pos_ext <= cnt_ext);
  assign ins_ok  = (position_r != '0) && (pos_ext <= cnt_ext + PW'(1));
  assign full    = (count_r == CW'(CAPACITY));

  always_comb begin
    store_nxt      = store_r;
    count_nxt      = count_r;
    read_value_nxt = '0;
    status_nxt     = ST_OK;
    if (in_valid_r) begin
      case (kind_r)
        OP_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (cnt_ext == PW'(i)) begin
                store_nxt[i] = value_r;
              end
            end
            count_nxt = count_r + CW'(1);
          end
        end
        OP_INSERT: begin
          if (!ins_ok) begin
            status_nxt = ST_RANGE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            // Slots above the insertion point move up by one.
            for (int i = 0; i < CAPACITY; i++) begin
              if (PW'(i) == p0) begin
                store_nxt[i] = value_r;
              end else if (i > 0) begin
                if (PW'(i) > p0) begin
                  store_nxt[i] = store_r[i-1];
                end
              end
            end
            count_nxt = count_r + CW'(1);
          end
        end
        OP_DELETE: begin
          if (!pos_ok) begin
            status_nxt = ST_RANGE;
          end else begin
            // Slots from the deleted one upward take their upper neighbor.
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (PW'(i) >= p0) begin
                store_nxt[i] = store_r[i+1];
              end
            end
            count_nxt = count_r - CW'(1);
          end
        end
        OP_REPLACE: begin
          if (!pos_ok) begin
            status_nxt = ST_RANGE;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (PW'(i) == p0) begin
                store_nxt[i] = value_r;
              end
            end
          end
        end
        OP_READ: begin
          if (!pos_ok) begin
            status_nxt = ST_RANGE;
          end else begin
            read_value_nxt = store_r[p0[IW-1:0]];
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          // Unused operation codes change nothing and report ok.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r     <= in_kind;
      position_r <= in_position;
      value_r    <= in_value;
    end
    if (in_valid_r) begin
      read_value_r <= read_value_nxt;
      count_out_r  <= count_nxt;
      status_r     <= status_nxt;
    end
    store_r <= store_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = read_value_r;
  assign out_element_count = COUNT_W'(count_out_r);
  assign out_status        = status_r;

  // Every item taken produces a result once it has passed the input and result registers.
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted item produced no result");

  // No result appears without an item taken before it.
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // The element count never exceeds the list capacity.
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  // A full status is only given while the list really is full.
  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (count_r == CW'(CAPACITY)))
    else $error("full status with room left");

  // A failed operation never returns data.
  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_value == '0))
    else $error("data returned with error status");

endmodule

`default_nettype wire
